FILE: hw/rtl/sfd_pkg.sv
// Shared types and constants for the sync-header frame deframer.
// No dependencies; imported by every module of the block.
package sfd_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 1;

    typedef logic [BYTE_W-1:0]    t_byte;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Configuration register indexes
    localparam t_cfg_idx CFG_SYNC_FIRST  = 1'b0;
    localparam t_cfg_idx CFG_SYNC_SECOND = 1'b1;

    localparam t_byte SYNC_FIRST_RESET  = 8'hBB;
    localparam t_byte SYNC_SECOND_RESET = 8'h55;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef struct packed {
        t_byte first;
        t_byte second;
    } t_sync_cfg;

    typedef struct packed {
        logic  kind;
        t_byte data_byte;
        t_byte byte_index;
        t_byte frame_id;
        t_byte frame_mode;
        t_byte frame_length;
        logic  frame_ok;
    } t_result;

endpackage

FILE: hw/rtl/sfd_cfg_regs.sv
// Sync byte configuration registers with a valid/ready write port.
// Depends on sfd_pkg.
module sfd_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  sfd_pkg::t_cfg_idx i_cfg_index,
    input  sfd_pkg::t_byte    i_cfg_data,
    output sfd_pkg::t_sync_cfg o_sync
);
    import sfd_pkg::*;

    t_sync_cfg r_sync;

    assign o_cfg_ready = 1'b1;
    assign o_sync      = r_sync;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync.first  <= SYNC_FIRST_RESET;
            r_sync.second <= SYNC_SECOND_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SYNC_FIRST:  r_sync.first  <= i_cfg_data;
                CFG_SYNC_SECOND: r_sync.second <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

FILE: hw/rtl/sfd_parser.sv
// Frame parser: phase machine, Fletcher sums and the result register.
// Depends on sfd_pkg.
module sfd_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_byte_valid,
    input  sfd_pkg::t_byte     i_byte,
    input  sfd_pkg::t_sync_cfg i_sync,
    input  logic               i_stall,
    output logic               o_advance,
    output logic               o_valid,
    output sfd_pkg::t_result   o_result
);
    import sfd_pkg::*;

    typedef enum logic [2:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_LEN,
        PH_MODE,
        PH_ID,
        PH_PAYLOAD,
        PH_CHK1,
        PH_CHK2
    } t_phase;

    t_phase  r_phase, n_phase;
    t_byte   r_length, n_length;
    t_byte   r_mode, n_mode;
    t_byte   r_id, n_id;
    t_byte   r_count, n_count;
    t_byte   r_sum_a, n_sum_a;
    t_byte   r_sum_b, n_sum_b;
    t_byte   r_chk1, n_chk1;
    logic    r_valid;
    t_result r_result;

    logic    w_emit;
    t_result w_result;
    t_byte   w_acc_a;
    t_byte   w_count_inc;

    // The result register frees up when empty or taken this cycle
    assign o_advance = !r_valid || !i_stall;
    assign o_valid   = r_valid;
    assign o_result  = r_result;

    assign w_acc_a     = r_sum_a + i_byte;
    assign w_count_inc = r_count + 8'd1;

    always_comb begin
        n_phase  = r_phase;
        n_length = r_length;
        n_mode   = r_mode;
        n_id     = r_id;
        n_count  = r_count;
        n_sum_a  = r_sum_a;
        n_sum_b  = r_sum_b;
        n_chk1   = r_chk1;
        w_emit   = 1'b0;
        w_result = '{kind: KIND_PAYLOAD, data_byte: i_byte, byte_index: r_count,
                     frame_id: r_id, frame_mode: r_mode, frame_length: r_length,
                     frame_ok: 1'b0};
        case (r_phase)
            PH_SYNC1: begin
                if (i_byte == i_sync.first) n_phase = PH_SYNC2;
            end
            PH_SYNC2: begin
                n_phase = (i_byte == i_sync.second) ? PH_LEN : PH_SYNC1;
            end
            PH_LEN: begin
                n_length = i_byte;
                n_sum_a  = w_acc_a;
                n_sum_b  = r_sum_b + w_acc_a;
                n_phase  = PH_MODE;
            end
            PH_MODE: begin
                n_mode  = i_byte;
                n_sum_a = w_acc_a;
                n_sum_b = r_sum_b + w_acc_a;
                n_phase = PH_ID;
            end
            PH_ID: begin
                n_id    = i_byte;
                n_sum_a = w_acc_a;
                n_sum_b = r_sum_b + w_acc_a;
                // zero-length frame skips the payload
                n_phase = (r_length == '0) ? PH_CHK1 : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                n_sum_a = w_acc_a;
                n_sum_b = r_sum_b + w_acc_a;
                w_emit  = 1'b1;
                n_count = w_count_inc;
                if (w_count_inc >= r_length) n_phase = PH_CHK1;
            end
            PH_CHK1: begin
                n_chk1  = i_byte;
                n_phase = PH_CHK2;
            end
            PH_CHK2: begin
                w_emit              = 1'b1;
                w_result.kind       = KIND_VERDICT;
                w_result.data_byte  = '0;
                w_result.byte_index = '0;
                w_result.frame_ok   = (r_chk1 == r_sum_a) && (i_byte == r_sum_b);
                n_count             = '0;
                n_sum_a             = '0;
                n_sum_b             = '0;
                n_phase             = PH_SYNC1;
            end
            default: begin
                n_phase = PH_SYNC1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SYNC1;
            r_length <= '0;
            r_mode   <= '0;
            r_id     <= '0;
            r_count  <= '0;
            r_sum_a  <= '0;
            r_sum_b  <= '0;
            r_chk1   <= '0;
            r_valid  <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_byte_valid && w_emit;
            if (i_byte_valid) begin
                r_phase  <= n_phase;
                r_length <= n_length;
                r_mode   <= n_mode;
                r_id     <= n_id;
                r_count  <= n_count;
                r_sum_a  <= n_sum_a;
                r_sum_b  <= n_sum_b;
                r_chk1   <= n_chk1;
                if (w_emit) r_result <= w_result;
            end
        end
    end

endmodule

FILE: hw/rtl/sync_frame_deframer_fletcher8.sv
// Top level of the sync-header frame deframer with Fletcher-8 check.
// Depends on sfd_pkg, sfd_cfg_regs and sfd_parser.
//
//   channel   signals                                    direction
//   input     i_valid, o_stall, i_rx_byte                 in
//   output    o_valid, i_stall, o_kind .. o_frame_ok      out
//   config    i_cfg_valid, o_cfg_ready, i_cfg_index,      in
//             i_cfg_data
//
// One byte per cycle while the output does not stall; each byte is held in the input
// register and any result it yields is then written into the result register.
// The phase machine and the two 8-bit sums update once per byte.
// Reset is synchronous: the block hunts for the first sync byte afterwards.
// Output stall holds the result register and backs up through the input
// register; a waiting byte holds there whether or not it yields a result.
module sync_frame_deframer_fletcher8 (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  sfd_pkg::t_byte    i_rx_byte,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_kind,
    output sfd_pkg::t_byte    o_data_byte,
    output sfd_pkg::t_byte    o_byte_index,
    output sfd_pkg::t_byte    o_frame_id,
    output sfd_pkg::t_byte    o_frame_mode,
    output sfd_pkg::t_byte    o_frame_length,
    output logic              o_frame_ok,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  sfd_pkg::t_cfg_idx i_cfg_index,
    input  sfd_pkg::t_byte    i_cfg_data
);
    import sfd_pkg::*;

    t_sync_cfg w_sync;
    t_result   w_result;
    logic      w_advance;
    logic      r_in_valid;
    t_byte     r_in_byte;

    sfd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_sync      (w_sync)
    );

    sfd_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (r_in_valid),
        .i_byte       (r_in_byte),
        .i_sync       (w_sync),
        .i_stall      (i_stall),
        .o_advance    (w_advance),
        .o_valid      (o_valid),
        .o_result     (w_result)
    );

    // Hold the input register while its byte cannot move on
    assign o_stall = r_in_valid && !w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
            if (i_valid) r_in_byte <= i_rx_byte;
        end
    end

    assign o_kind         = w_result.kind;
    assign o_data_byte    = w_result.data_byte;
    assign o_byte_index   = w_result.byte_index;
    assign o_frame_id     = w_result.frame_id;
    assign o_frame_mode   = w_result.frame_mode;
    assign o_frame_length = w_result.frame_length;
    assign o_frame_ok     = w_result.frame_ok;

endmodule

FILE: hw/rtl/sfd_checker.sv
// Port-level checks for the deframer top level, bound in below.
// Depends on sfd_pkg and sync_frame_deframer_fletcher8.
module sfd_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_stall,
    input logic              o_kind,
    input sfd_pkg::t_byte    o_data_byte,
    input sfd_pkg::t_byte    o_byte_index,
    input sfd_pkg::t_byte    o_frame_id,
    input sfd_pkg::t_byte    o_frame_mode,
    input sfd_pkg::t_byte    o_frame_length,
    input logic              o_frame_ok
);
    import sfd_pkg::*;

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_data_byte)
            && $stable(o_byte_index) && $stable(o_frame_id) && $stable(o_frame_mode)
            && $stable(o_frame_length) && $stable(o_frame_ok))
        else $error("stalled result changed");

    a_verdict_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_VERDICT |-> o_data_byte == '0 && o_byte_index == '0)
        else $error("verdict carries payload fields");

    a_index_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_PAYLOAD |-> o_byte_index < o_frame_length && !o_frame_ok)
        else $error("payload index beyond declared length");

endmodule

bind sync_frame_deframer_fletcher8 sfd_checker u_sfd_checker (.*);

FILE: bench/sync_frame_deframer_fletcher8_tb.sv
// Self-checking bench for sync_frame_deframer_fletcher8: drives framed byte streams
// under several sync settings and checks every result against a frame predictor.
// Depends on sfd_pkg and the sync_frame_deframer_fletcher8 RTL.
`timescale 1ns / 1ps

module sync_frame_deframer_fletcher8_tb;
    import sfd_pkg::*;

    localparam int CLK_HALF_NS  = 6;
    localparam int RESET_CYCLES = 5;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int IDLE_PCT     = 32;
    localparam int PHASE_BYTES  = 55;

    typedef enum logic [2:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        TAKE_LENGTH,
        TAKE_MODE,
        TAKE_ID,
        TAKE_PAYLOAD,
        TAKE_CHECK_A,
        TAKE_CHECK_B
    } t_deframe_phase;

    typedef t_byte t_byte_q[$];

    // Tracks the deframer state and holds the results still owed by the block.
    class t_frame_tracker;
        t_sync_cfg      sync;
        t_deframe_phase phase;
        t_byte          length_r;
        t_byte          mode_r;
        t_byte          id_r;
        t_byte          count_r;
        t_byte          sum_a;
        t_byte          sum_b;
        t_byte          check_a;
        t_result        pending[$];
        int unsigned    errors;

        function new();
            sync.first  = SYNC_FIRST_RESET;
            sync.second = SYNC_SECOND_RESET;
            phase       = HUNT_FIRST;
            length_r    = '0;
            mode_r      = '0;
            id_r        = '0;
            count_r     = '0;
            sum_a       = '0;
            sum_b       = '0;
            check_a     = '0;
            errors      = 0;
        endfunction

        function void set_sync(t_cfg_idx idx, t_byte value);
            if (idx == CFG_SYNC_FIRST) begin
                sync.first = value;
            end else if (idx == CFG_SYNC_SECOND) begin
                sync.second = value;
            end
        endfunction

        function void add_to_sums(t_byte b);
            sum_a = sum_a + b;
            sum_b = sum_b + sum_a;
        endfunction

        function void take_byte(t_byte b);
            t_result r;
            r              = '0;
            r.frame_id     = id_r;
            r.frame_mode   = mode_r;
            r.frame_length = length_r;
            case (phase)
                HUNT_FIRST: begin
                    if (b == sync.first) phase = HUNT_SECOND;
                end
                HUNT_SECOND: begin
                    // a wrong second byte is not retried as a first sync byte
                    phase = (b == sync.second) ? TAKE_LENGTH : HUNT_FIRST;
                end
                TAKE_LENGTH: begin
                    length_r = b;
                    add_to_sums(b);
                    phase = TAKE_MODE;
                end
                TAKE_MODE: begin
                    mode_r = b;
                    add_to_sums(b);
                    phase = TAKE_ID;
                end
                TAKE_ID: begin
                    id_r = b;
                    add_to_sums(b);
                    phase = (length_r == '0) ? TAKE_CHECK_A : TAKE_PAYLOAD;
                end
                TAKE_PAYLOAD: begin
                    add_to_sums(b);
                    r.kind       = KIND_PAYLOAD;
                    r.data_byte  = b;
                    r.byte_index = count_r;
                    r.frame_id   = id_r;
                    pending      = {pending, r};
                    count_r = count_r + 1'b1;
                    if (count_r >= length_r) phase = TAKE_CHECK_A;
                end
                TAKE_CHECK_A: begin
                    check_a = b;
                    phase   = TAKE_CHECK_B;
                end
                TAKE_CHECK_B: begin
                    r.kind     = KIND_VERDICT;
                    r.frame_ok = (check_a == sum_a) && (b == sum_b);
                    pending    = {pending, r};
                    phase   = HUNT_FIRST;
                    count_r = '0;
                    sum_a   = '0;
                    sum_b   = '0;
                end
                default: begin
                    phase = HUNT_FIRST;
                end
            endcase
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                errors++;
                $display({"%0t: result with none expected, expected nothing,",
                          " actual kind %0d data 0x%0h"},
                         $time, got.kind, got.data_byte);
                return;
            end
            want = pending.pop_front();
            check_field("kind", want.kind, got.kind);
            check_field("data_byte", want.data_byte, got.data_byte);
            check_field("byte_index", want.byte_index, got.byte_index);
            check_field("frame_id", want.frame_id, got.frame_id);
            check_field("frame_mode", want.frame_mode, got.frame_mode);
            check_field("frame_length", want.frame_length, got.frame_length);
            check_field("frame_ok", want.frame_ok, got.frame_ok);
        endfunction
    endclass

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_stall;
    t_byte    i_rx_byte;
    logic     o_valid;
    logic     i_stall = 1'b0;
    logic     o_kind;
    t_byte    o_data_byte;
    t_byte    o_byte_index;
    t_byte    o_frame_id;
    t_byte    o_frame_mode;
    t_byte    o_frame_length;
    logic     o_frame_ok;
    logic     i_cfg_valid;
    logic     o_cfg_ready;
    t_cfg_idx i_cfg_index;
    t_byte    i_cfg_data;

    bit             no_idle     = 1'b0;
    int unsigned    bytes_sent  = 0;
    int unsigned    cycle_count = 0;
    t_frame_tracker tracker     = new();

    sync_frame_deframer_fletcher8 dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_data_byte    (o_data_byte),
        .o_byte_index   (o_byte_index),
        .o_frame_id     (o_frame_id),
        .o_frame_mode   (o_frame_mode),
        .o_frame_length (o_frame_length),
        .o_frame_ok     (o_frame_ok),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #CLK_HALF_NS;
        i_clk = 1'b1;
        #CLK_HALF_NS;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: no progress within the cycle limit", $time);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Check each result transfer, then pick the stall for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            tracker.check_result('{kind: o_kind, data_byte: o_data_byte,
                                   byte_index: o_byte_index, frame_id: o_frame_id,
                                   frame_mode: o_frame_mode,
                                   frame_length: o_frame_length,
                                   frame_ok: o_frame_ok});
        end
        i_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
    end

    task automatic send_byte(input t_byte b);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
        tracker.take_byte(b);
        bytes_sent++;
    endtask

    // Drop valid and hold off until every owed result has been transferred.
    task automatic hold_until_drained();
        i_valid <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_byte value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.set_sync(idx, value);
    endtask

    task automatic apply_sync(input t_byte first, input t_byte second);
        hold_until_drained();
        write_reg(CFG_SYNC_FIRST, first);
        write_reg(CFG_SYNC_SECOND, second);
        i_cfg_valid <= 1'b0;
    endtask

    // Random byte that cannot start a frame while hunting.
    function automatic t_byte noise_byte();
        t_byte b;
        b = t_byte'($urandom_range(255));
        if (b == tracker.sync.first) b = ~b;
        return b;
    endfunction

    function automatic t_byte_q random_payload(int unsigned n);
        t_byte_q q;
        repeat (n) q = {q, t_byte'($urandom_range(255))};
        return q;
    endfunction

    // bad[0] corrupts the sum A check byte, bad[1] the sum B check byte.
    task automatic send_frame(input t_byte mode, input t_byte id, input t_byte_q payload,
                              input logic [1:0] bad);
        t_byte_q body;
        t_byte   sum_a;
        t_byte   sum_b;
        // flush any partial frame left by a broken sequence
        while (tracker.phase != HUNT_FIRST) send_byte(t_byte'($urandom_range(255)));
        body = payload;
        body.push_front(id);
        body.push_front(mode);
        body.push_front(t_byte'(payload.size()));
        sum_a = '0;
        sum_b = '0;
        foreach (body[i]) begin
            sum_a = sum_a + body[i];
            sum_b = sum_b + sum_a;
        end
        if (bad[0]) sum_a = sum_a ^ t_byte'($urandom_range(1, 255));
        if (bad[1]) sum_b = sum_b ^ t_byte'($urandom_range(1, 255));
        send_byte(tracker.sync.first);
        send_byte(tracker.sync.second);
        foreach (body[i]) send_byte(body[i]);
        send_byte(sum_a);
        send_byte(sum_b);
    endtask

    task automatic random_traffic(input int unsigned budget);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned n;
        t_byte       b;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                repeat ($urandom_range(2)) send_byte(noise_byte());
                n = ($urandom_range(99) < 75) ? $urandom_range(4) : $urandom_range(5, 24);
                send_frame(t_byte'($urandom_range(255)), t_byte'($urandom_range(255)),
                           random_payload(n),
                           ($urandom_range(99) < 25) ? 2'($urandom_range(1, 3)) : 2'd0);
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 4)) send_byte(noise_byte());
            end else if (pick < 88) begin
                b = t_byte'($urandom_range(255));
                if (b == tracker.sync.second) b = ~b;
                send_byte(tracker.sync.first);
                send_byte(b);
            end else if (pick < 96) begin
                // header with a short length, cut off at a random point
                n = $urandom_range(6);
                send_byte(tracker.sync.first);
                send_byte(tracker.sync.second);
                send_byte(t_byte'(n));
                repeat ($urandom_range(n + 3)) send_byte(t_byte'($urandom_range(255)));
            end else begin
                hold_until_drained();
            end
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_rx_byte   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_SYNC_FIRST;
        i_cfg_data  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: noise extremes, bad second sync, empty frame, bad check
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SYNC_FIRST_RESET);
        send_byte(8'h00);
        send_frame(8'hFF, 8'h00, random_payload(0), 2'd0);
        send_frame(8'h00, 8'hFF, '{8'hFF, 8'h00}, 2'd2);

        // longest frame, then random traffic under several sync settings
        send_frame(t_byte'($urandom_range(255)), t_byte'($urandom_range(255)),
                   random_payload(255), 2'd0);
        random_traffic(PHASE_BYTES);
        apply_sync(8'h00, 8'hFF);
        no_idle = 1'b1;
        random_traffic(PHASE_BYTES);
        no_idle = 1'b0;
        apply_sync(8'hFF, 8'h00);
        random_traffic(PHASE_BYTES);
        apply_sync(8'hA5, 8'hA5);
        random_traffic(PHASE_BYTES);
        apply_sync(t_byte'($urandom_range(255)), t_byte'($urandom_range(255)));
        random_traffic(PHASE_BYTES);
        apply_sync(SYNC_FIRST_RESET, SYNC_SECOND_RESET);
        random_traffic(PHASE_BYTES);
        hold_until_drained();

        if (tracker.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/sfd_pkg.sv
hw/rtl/sfd_cfg_regs.sv
hw/rtl/sfd_parser.sv
hw/rtl/sync_frame_deframer_fletcher8.sv
hw/rtl/sfd_checker.sv
bench/sync_frame_deframer_fletcher8_tb.sv
